>>> sv/rsvb_pkg.sv
`default_nettype none
package rsvb_pkg;

   // result status codes
   localparam logic [1:0] STATUS_ACC  = 2'd0;
   localparam logic [1:0] STATUS_OUT  = 2'd1;
   localparam logic [1:0] STATUS_ZDIV = 2'd2;

   // configuration register indexes
   localparam logic [2:0] REG_ORIGIN_X = 3'd0;
   localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
   localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
   localparam logic [2:0] REG_STEP_X   = 3'd3;
   localparam logic [2:0] REG_STEP_Y   = 3'd4;
   localparam logic [2:0] REG_STEP_Z   = 3'd5;

   localparam int SUM_W  = 48;
   localparam int HIT_W  = 24;
   localparam int NUM_W  = 43;   // axis numerator h*(step+pos-origin)
   localparam int DIV_W  = 32;   // divisor width of the shared divider
   localparam int LOW_W  = 48;   // dividend bits shifted in by the divider
   localparam int CNT_W  = 6;
   localparam int AXQ_W  = 8;    // axis quotient bits (index below 256)
   localparam int LIN_W  = 24;

   localparam logic [SUM_W-1:0] SUM_MAX = '1;
   localparam logic [HIT_W-1:0] HIT_MAX = '1;

   // divider command: load remainder and dividend tail, run a number of steps
   typedef struct packed {
      logic             start;
      logic [CNT_W-1:0] steps;
      logic [DIV_W-1:0] rem_init;
      logic [LOW_W-1:0] low_init;
   } div_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage
`default_nettype wire

>>> sv/rsvb_ram.sv
`default_nettype none
module rsvb_ram #(
   parameter int WIDTH = 72,
   parameter int DEPTH = 32768
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> sv/rsvb_div.sv
`default_nettype none
module rsvb_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire rsvb_pkg::div_cmd_type       cmd,
   input  wire logic [rsvb_pkg::DIV_W-1:0]  divisor,
   output rsvb_pkg::div_stat_type           stat,
   output logic      [rsvb_pkg::LOW_W-1:0]  quotient,
   output logic      [rsvb_pkg::DIV_W-1:0]  remainder
);

   logic                        busy_ff;
   logic [rsvb_pkg::CNT_W-1:0]  cnt_ff;
   logic [rsvb_pkg::DIV_W-1:0]  rem_ff, rem_in;
   logic [rsvb_pkg::LOW_W-1:0]  low_ff;
   logic [rsvb_pkg::LOW_W-1:0]  quo_ff;
   logic [rsvb_pkg::DIV_W:0]    trial;
   logic                        qbit;

   // one restoring step: shift in next dividend bit, subtract if it fits
   always_comb begin
      trial = {rem_ff, low_ff[rsvb_pkg::LOW_W-1]};
      qbit  = (trial >= {1'b0, divisor});
      if (qbit) begin
         rem_in = rsvb_pkg::DIV_W'(trial - {1'b0, divisor});
      end else begin
         rem_in = trial[rsvb_pkg::DIV_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (cmd.start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= cmd.steps;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == rsvb_pkg::CNT_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         rem_ff <= cmd.rem_init;
         low_ff <= cmd.low_init;
         quo_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         low_ff <= {low_ff[rsvb_pkg::LOW_W-2:0], 1'b0};
         quo_ff <= {quo_ff[rsvb_pkg::LOW_W-2:0], qbit};
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = busy_ff && (cnt_ff == rsvb_pkg::CNT_W'(1));
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

>>> sv/reciprocal_space_voxel_binner_unit.sv
// A point inside the volume takes up to three 8-step axis divisions plus a 48-step weight division
//   on one shared divider; a saturating weight skips the weight division, a point outside the
//   volume ends at its failing axis, and a zero divisor goes straight to the result.
// Throughput: one point at a time; the next transfer can be taken in the cycle after the result
//   is issued, later while the result register is still full; the divider sets the rate.
// Reset: synchronous; afterwards all VOL_X*VOL_Y*VOL_Z entries (32768 by default) of the voxel
//   store are cleared one entry per cycle, with req_ready low meanwhile.
`default_nettype none
module reciprocal_space_voxel_binner_unit #(
   parameter int VOL_X = 32,
   parameter int VOL_Y = 32,
   parameter int VOL_Z = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_pos_x,
   input  wire logic [31:0] req_pos_y,
   input  wire logic [31:0] req_pos_z,
   input  wire logic [31:0] req_intensity,
   input  wire logic [15:0] req_polarization,
   input  wire logic [15:0] req_correction,
   input  wire logic        req_last_point,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [14:0]      rsp_voxel_index,
   output logic [47:0]      rsp_voxel_sum,
   output logic [23:0]      rsp_voxel_hits,
   output logic             rsp_frame_end,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   localparam int NVOX   = VOL_X * VOL_Y * VOL_Z;
   localparam int AW     = $clog2(NVOX);
   localparam int RAM_W  = rsvb_pkg::SUM_W + rsvb_pkg::HIT_W;
   localparam logic [7:0] H_X = 8'((VOL_X - 1) / 2);
   localparam logic [7:0] H_Y = 8'((VOL_Y - 1) / 2);
   localparam logic [7:0] H_Z = 8'((VOL_Z - 1) / 2);
   localparam logic [AW-1:0] LAST_ADDR = AW'(NVOX - 1);

   typedef enum logic [12:0] {
      S_CLEAR  = 13'b0000000000001,
      S_IDLE   = 13'b0000000000010,
      S_AX_MUL = 13'b0000000000100,
      S_AX_CHK = 13'b0000000001000,
      S_AX_DIV = 13'b0000000010000,
      S_AX_RND = 13'b0000000100000,
      S_W_MUL  = 13'b0000001000000,
      S_W_CHK  = 13'b0000010000000,
      S_W_DIV  = 13'b0000100000000,
      S_W_RND  = 13'b0001000000000,
      S_RD     = 13'b0010000000000,
      S_UPD    = 13'b0100000000000,
      S_DONE   = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic signed [31:0] org_ff [3];
   logic        [30:0] step_ff [3];

   // captured point
   logic signed [31:0] pos_ff [3];
   logic        [31:0] inten_ff;
   logic        [15:0] pol_ff, cor_ff;
   logic               last_ff;

   logic [1:0]                 ax_ff;
   logic [7:0]                 idx_ff [3];
   logic signed [rsvb_pkg::NUM_W-1:0] num_ff;
   logic [39:0]                bound_ff;
   logic [rsvb_pkg::DIV_W-1:0] dsr_ff;
   logic [rsvb_pkg::SUM_W-1:0] w_ff;
   logic [AW-1:0]              clr_ff;

   // result staging and output register
   logic [1:0]                 res_status_ff;
   logic [14:0]                res_idx_ff;
   logic [rsvb_pkg::SUM_W-1:0] res_sum_ff;
   logic [rsvb_pkg::HIT_W-1:0] res_hits_ff;
   logic                       rsp_valid_ff;
   logic [1:0]                 rsp_status_ff;
   logic [14:0]                rsp_idx_ff;
   logic [rsvb_pkg::SUM_W-1:0] rsp_sum_ff;
   logic [rsvb_pkg::HIT_W-1:0] rsp_hits_ff;
   logic                       rsp_end_ff;

   rsvb_pkg::div_cmd_type      div_cmd;
   rsvb_pkg::div_stat_type     div_stat;
   logic [rsvb_pkg::LOW_W-1:0] div_quo;
   logic [rsvb_pkg::DIV_W-1:0] div_rem;

   logic signed [31:0] sel_pos, sel_org;
   logic        [30:0] sel_step;
   logic        [7:0]  sel_h;
   logic        [8:0]  sel_vol;
   logic signed [32:0] diff;
   logic signed [33:0] sdiff;
   logic signed [rsvb_pkg::NUM_W-1:0] num_in;
   logic signed [rsvb_pkg::NUM_W-1:0] neg_r;
   logic               neg_in_vol;
   logic               ax_round;
   logic [8:0]         ax_q;
   logic               w_round;
   logic [48:0]        w_q;
   logic [rsvb_pkg::LIN_W-1:0] lin;
   logic [rsvb_pkg::SUM_W:0]   sum_wide;
   logic [rsvb_pkg::SUM_W-1:0] sum_new, sum_old;
   logic [rsvb_pkg::HIT_W-1:0] hits_new, hits_old;
   logic               out_free;
   logic               ram_we, ram_re;
   logic [AW-1:0]      ram_waddr;
   logic [RAM_W-1:0]   ram_wdata, ram_rdata;

   // current axis operands
   always_comb begin
      case (ax_ff)
         2'd0: begin
            sel_pos = pos_ff[0]; sel_org = org_ff[0]; sel_step = step_ff[0];
            sel_h = H_X; sel_vol = 9'(VOL_X);
         end
         2'd1: begin
            sel_pos = pos_ff[1]; sel_org = org_ff[1]; sel_step = step_ff[1];
            sel_h = H_Y; sel_vol = 9'(VOL_Y);
         end
         default: begin
            sel_pos = pos_ff[2]; sel_org = org_ff[2]; sel_step = step_ff[2];
            sel_h = H_Z; sel_vol = 9'(VOL_Z);
         end
      endcase
   end

   // axis numerator h*(step + pos - origin)
   assign diff   = 33'(sel_pos) - 33'(sel_org);
   assign sdiff  = 34'(diff) + $signed({3'b0, sel_step});
   assign num_in = rsvb_pkg::NUM_W'(sdiff) * rsvb_pkg::NUM_W'($signed({1'b0, sel_h}));

   // negative numerator: index 0 only if floor is -1 and it rounds up
   assign neg_r      = num_ff + $signed({12'b0, step_ff[ax_ff]});
   assign neg_in_vol = !neg_r[rsvb_pkg::NUM_W-1]
                       && ({neg_r[31:0], 1'b0} >= {2'b0, step_ff[ax_ff]});

   // round half to even on divider results
   assign ax_round = ({div_rem, 1'b0} > {1'b0, dsr_ff})
                     || (({div_rem, 1'b0} == {1'b0, dsr_ff}) && div_quo[0]);
   assign ax_q     = {1'b0, div_quo[rsvb_pkg::AXQ_W-1:0]} + 9'(ax_round);
   assign w_round  = ax_round;
   assign w_q      = {1'b0, div_quo} + 49'(w_round);

   assign lin = rsvb_pkg::LIN_W'((rsvb_pkg::LIN_W'(idx_ff[2]) * rsvb_pkg::LIN_W'(VOL_Y)
                + rsvb_pkg::LIN_W'(idx_ff[1])) * rsvb_pkg::LIN_W'(VOL_X)
                + rsvb_pkg::LIN_W'(idx_ff[0]));

   // saturating read-modify-write values
   assign sum_old  = ram_rdata[RAM_W-1:rsvb_pkg::HIT_W];
   assign hits_old = ram_rdata[rsvb_pkg::HIT_W-1:0];
   assign sum_wide = {1'b0, sum_old} + {1'b0, w_ff};
   assign sum_new  = sum_wide[rsvb_pkg::SUM_W] ? rsvb_pkg::SUM_MAX
                                               : sum_wide[rsvb_pkg::SUM_W-1:0];
   assign hits_new = (hits_old == rsvb_pkg::HIT_MAX) ? hits_old : hits_old + 1'b1;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // divider commands
   always_comb begin
      div_cmd = '0;
      if (state_ff == S_AX_CHK && !num_ff[rsvb_pkg::NUM_W-1]
          && (num_ff[39:0] < bound_ff) && (num_ff[41:40] == 2'b0)) begin
         div_cmd.start    = 1'b1;
         div_cmd.steps    = rsvb_pkg::CNT_W'(rsvb_pkg::AXQ_W);
         div_cmd.rem_init = num_ff[rsvb_pkg::DIV_W+7:8];
         div_cmd.low_init = {num_ff[7:0], 40'b0};
      end else if (state_ff == S_W_CHK && ({20'b0, inten_ff} < {dsr_ff, 20'b0})) begin
         div_cmd.start    = 1'b1;
         div_cmd.steps    = rsvb_pkg::CNT_W'(rsvb_pkg::SUM_W);
         div_cmd.rem_init = {20'b0, inten_ff[31:20]};
         div_cmd.low_init = {inten_ff[19:0], 28'b0};
      end
   end

   rsvb_div u_div (
      .clock     (clock),
      .reset     (reset),
      .cmd       (div_cmd),
      .divisor   (dsr_ff),
      .stat      (div_stat),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // voxel store: sum in the upper bits, hit count in the lower
   assign ram_we    = (state_ff == S_CLEAR) || (state_ff == S_UPD);
   assign ram_waddr = (state_ff == S_CLEAR) ? clr_ff : lin[AW-1:0];
   assign ram_wdata = (state_ff == S_CLEAR) ? '0 : {sum_new, hits_new};
   assign ram_re    = (state_ff == S_RD);

   rsvb_ram #(
      .WIDTH (RAM_W),
      .DEPTH (NVOX)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (lin[AW-1:0]),
      .rd_data (ram_rdata)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR:  if (clr_ff == LAST_ADDR) state_in = S_IDLE;
         S_IDLE: begin
            if (req_valid) begin
               if (req_polarization == 16'd0 || req_correction == 16'd0) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_AX_MUL;
               end
            end
         end
         S_AX_MUL: state_in = S_AX_CHK;
         S_AX_CHK: begin
            if (div_cmd.start) begin
               state_in = S_AX_DIV;
            end else if (num_ff[rsvb_pkg::NUM_W-1] && neg_in_vol) begin
               state_in = (ax_ff == 2'd2) ? S_W_MUL : S_AX_MUL;
            end else begin
               state_in = S_DONE;
            end
         end
         S_AX_DIV: if (div_stat.done) state_in = S_AX_RND;
         S_AX_RND: begin
            if (ax_q >= sel_vol) begin
               state_in = S_DONE;
            end else begin
               state_in = (ax_ff == 2'd2) ? S_W_MUL : S_AX_MUL;
            end
         end
         S_W_MUL:  state_in = S_W_CHK;
         S_W_CHK:  state_in = div_cmd.start ? S_W_DIV : S_RD;
         S_W_DIV:  if (div_stat.done) state_in = S_W_RND;
         S_W_RND:  state_in = S_RD;
         S_RD:     state_in = S_UPD;
         S_UPD:    state_in = S_DONE;
         S_DONE:   if (out_free) state_in = S_IDLE;
         default:  state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            org_ff[i]  <= '0;
            step_ff[i] <= 31'd65536;
         end
      end else if (csr_valid) begin
         unique case (csr_index)
            rsvb_pkg::REG_ORIGIN_X: org_ff[0]  <= csr_wdata;
            rsvb_pkg::REG_ORIGIN_Y: org_ff[1]  <= csr_wdata;
            rsvb_pkg::REG_ORIGIN_Z: org_ff[2]  <= csr_wdata;
            rsvb_pkg::REG_STEP_X:   step_ff[0] <= csr_wdata[30:0];
            rsvb_pkg::REG_STEP_Y:   step_ff[1] <= csr_wdata[30:0];
            rsvb_pkg::REG_STEP_Z:   step_ff[2] <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ax_ff <= '0;
      end else begin
         if (state_ff == S_IDLE) begin
            ax_ff <= '0;
         end else if ((state_ff == S_AX_RND)
                      || (state_ff == S_AX_CHK && !div_cmd.start)) begin
            ax_ff <= ax_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            pos_ff[0]     <= req_pos_x;
            pos_ff[1]     <= req_pos_y;
            pos_ff[2]     <= req_pos_z;
            inten_ff      <= req_intensity;
            pol_ff        <= req_polarization;
            cor_ff        <= req_correction;
            last_ff       <= req_last_point;
            res_status_ff <= (req_polarization == 16'd0 || req_correction == 16'd0)
                             ? rsvb_pkg::STATUS_ZDIV : rsvb_pkg::STATUS_OUT;
            res_idx_ff    <= '0;
            res_sum_ff    <= '0;
            res_hits_ff   <= '0;
         end
         S_AX_MUL: begin
            num_ff   <= num_in;
            bound_ff <= 40'(sel_vol) * 40'(sel_step);
            dsr_ff   <= {1'b0, sel_step};
         end
         S_AX_CHK: idx_ff[ax_ff] <= '0;
         S_AX_RND: idx_ff[ax_ff] <= ax_q[7:0];
         S_W_MUL:  dsr_ff <= 32'(pol_ff) * 32'(cor_ff);
         S_W_CHK:  w_ff <= rsvb_pkg::SUM_MAX;
         S_W_RND:  w_ff <= w_q[48] ? rsvb_pkg::SUM_MAX : w_q[47:0];
         S_UPD: begin
            res_status_ff <= rsvb_pkg::STATUS_ACC;
            res_idx_ff    <= lin[14:0];
            res_sum_ff    <= sum_new;
            res_hits_ff   <= hits_new;
         end
         default: ;
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_DONE && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_DONE && out_free) begin
         rsp_status_ff <= res_status_ff;
         rsp_idx_ff    <= res_idx_ff;
         rsp_sum_ff    <= res_sum_ff;
         rsp_hits_ff   <= res_hits_ff;
         rsp_end_ff    <= last_ff;
      end
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_voxel_index = rsp_idx_ff;
   assign rsp_voxel_sum   = rsp_sum_ff;
   assign rsp_voxel_hits  = rsp_hits_ff;
   assign rsp_frame_end   = rsp_end_ff;

   // the store is cleared before any point is taken
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_ready)
      else $error("point accepted during clear pass");

   // an update never lowers the stored sum and always leaves a hit
   a_sum_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPD) |-> (sum_new >= sum_old) && (hits_new != '0))
      else $error("voxel update decreased the sum");

   // the divider only runs in a divide state or the cycle that starts it
   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> (state_ff == S_AX_DIV || state_ff == S_W_DIV))
      else $error("divider busy outside a divide state");

   // a finished point waits in DONE only while the result register is full
   a_done_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !out_free) |=> (state_ff == S_DONE))
      else $error("result dropped");

endmodule
`default_nettype wire
